// ===== sv/tcs_pkg.sv =====
// Shared types and constants for the text chunk splitter.
package tcs_pkg;

  // Split modes held in the mode register
  typedef enum logic [1:0] {
    MODE_PARA  = 2'd0,
    MODE_LINE  = 2'd1,
    MODE_PAGE  = 2'd2,
    MODE_WHOLE = 2'd3
  } mode_t;

  // Configuration register indexes
  localparam logic REG_SPLIT_MODE = 1'b0;
  localparam logic REG_MAX_PIECE  = 1'b1;

  localparam int unsigned CFG_DW = 16;

  localparam logic [7:0]  NL_BYTE       = 8'h0A;
  localparam logic [7:0]  FF_BYTE       = 8'h0C;
  localparam logic [15:0] DEFAULT_PIECE = 16'd4096;
  localparam logic [15:0] LEN_MAX       = 16'hFFFF;

  // Up to four results per input transaction
  localparam int unsigned MAX_RES = 4;
  localparam int unsigned RES_IW  = $clog2(MAX_RES);
  localparam int unsigned RES_CW  = $clog2(MAX_RES + 1);

  // Queue between front and back
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);
  localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

  // One result
  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       done;
  } res_t;

  typedef res_t [MAX_RES-1:0] res_arr_t;

  // One queue entry: the results of one input transaction
  typedef struct packed {
    res_arr_t          res;
    logic [RES_CW-1:0] cnt;
  } entry_t;

  // Queue status seen by the back end
  typedef struct packed {
    logic   valid;
    entry_t head;
  } q_head_t;

endpackage

// ===== sv/text_chunk_splitter.sv =====
// Top level of the text chunk splitter: front end, queue and back end.
//
//  channel  direction  handshake            payload
//  in       input      in_valid / in_stall  in_text_byte, in_byte_present, in_text_end
//  out      output     out_valid/out_stall  out_byte, out_byte_valid, out_chunk_done,
//                                           out_run_last
//  cfg      input      cfg_we               cfg_index, cfg_wdata
//
//  An input transaction is taken every cycle while the two-entry queue has room; it
//  makes zero to four results, and the back end sends one result per cycle unless
//  out_stall holds it. Results pass from the front end into a queue entry and
//  then into the output register before they appear on the out channel.
//  Reset is synchronous, active low; it restores paragraph mode, piece size 4096 and
//  clears the held newline and piece length.
//  A stall on the output fills the queue, which then stalls the input.
module text_chunk_splitter (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [tcs_pkg::CFG_DW-1:0] cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 in_text_byte,
  input  logic                       in_byte_present,
  input  logic                       in_text_end,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [7:0]                 out_byte,
  output logic                       out_byte_valid,
  output logic                       out_chunk_done,
  output logic                       out_run_last
);

  logic             q_full, q_push, q_pop;
  tcs_pkg::entry_t  q_entry;
  tcs_pkg::q_head_t q_head;

  tcs_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_text_byte    (in_text_byte),
    .in_byte_present (in_byte_present),
    .in_text_end     (in_text_end),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_entry         (q_entry)
  );

  tcs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_entry (q_entry),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head)
  );

  tcs_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (q_head),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_chunk_done (out_chunk_done),
    .out_run_last   (out_run_last)
  );

endmodule

// ===== sv/tcs_front.sv =====
// Front end: holds configuration and state, turns each byte into a result list.
module tcs_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [tcs_pkg::CFG_DW-1:0] cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 in_text_byte,
  input  logic                       in_byte_present,
  input  logic                       in_text_end,
  input  logic                       q_full,
  output logic                       q_push,
  output tcs_pkg::entry_t            q_entry
);

  tcs_pkg::mode_t mode_r;
  logic [15:0]    max_piece_r;
  logic           held_r, held_nxt;
  logic [15:0]    len_r, len_nxt;

  logic           accept;
  logic [15:0]    lim;

  // Content byte: bump the piece length, report a piece end when full; whole-text mode only counts, saturating
  function automatic logic [16:0] content_len(logic [15:0] len, tcs_pkg::mode_t mode,
                                              logic [15:0] lim_v);
    logic [15:0] nl;
    logic        dn;
    dn = 1'b0;
    if (mode == tcs_pkg::MODE_WHOLE) begin
      nl = (len != tcs_pkg::LEN_MAX) ? len + 16'd1 : len;
    end else begin
      nl = len + 16'd1;
      if (nl >= lim_v) begin
        dn = 1'b1;
        nl = '0;
      end
    end
    return {dn, nl};
  endfunction

  // Append a result if room is left
  function automatic tcs_pkg::res_arr_t put(tcs_pkg::res_arr_t a,
                                            logic [tcs_pkg::RES_CW-1:0] n,
                                            tcs_pkg::res_t r);
    tcs_pkg::res_arr_t b;
    b = a;
    if (n < tcs_pkg::RES_CW'(tcs_pkg::MAX_RES)) b[n[tcs_pkg::RES_IW-1:0]] = r;
    return b;
  endfunction

  function automatic logic [tcs_pkg::RES_CW-1:0] bump(logic [tcs_pkg::RES_CW-1:0] n);
    return (n < tcs_pkg::RES_CW'(tcs_pkg::MAX_RES)) ? n + 1'b1 : n;
  endfunction

  assign lim      = (max_piece_r == '0) ? tcs_pkg::DEFAULT_PIECE : max_piece_r;
  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  // Classification and result list
  always_comb begin
    logic                       c0, c1, cm, c2, sep, held_mid;
    logic [7:0]                 b0, b1;
    logic [15:0]                len;
    logic [16:0]                f;
    logic [tcs_pkg::RES_CW-1:0] n;
    tcs_pkg::res_arr_t          res;
    tcs_pkg::res_t              r_done;

    c0 = 1'b0; c1 = 1'b0; cm = 1'b0;
    b0 = tcs_pkg::NL_BYTE; b1 = in_text_byte;
    sep = 1'b0;
    f   = '0;
    r_done = '{data: 8'd0, valid: 1'b0, done: 1'b1};

    if (in_byte_present) begin
      if (mode_r == tcs_pkg::MODE_PARA) begin
        if (held_r) begin
          if (in_text_byte == tcs_pkg::NL_BYTE) cm = 1'b1;
          else begin
            c0 = 1'b1;
            c1 = 1'b1;
          end
        end else if (in_text_byte != tcs_pkg::NL_BYTE) begin
          c1 = 1'b1;
        end
      end else begin
        c0  = held_r;
        sep = (mode_r == tcs_pkg::MODE_LINE && in_text_byte == tcs_pkg::NL_BYTE) ||
              (mode_r == tcs_pkg::MODE_PAGE && in_text_byte == tcs_pkg::FF_BYTE);
        if (sep) cm = 1'b1;
        else     c1 = 1'b1;
      end
      held_mid = (mode_r == tcs_pkg::MODE_PARA) && !held_r &&
                 (in_text_byte == tcs_pkg::NL_BYTE);
    end else begin
      held_mid = held_r;
    end
    c2 = in_text_end && held_mid;

    len = len_r;
    n   = '0;
    res = '0;

    // released newline
    if (c0) begin
      res = put(res, n, '{data: b0, valid: 1'b1, done: 1'b0});
      n   = bump(n);
      f   = content_len(len, mode_r, lim);
      len = f[15:0];
      if (f[16]) begin
        res = put(res, n, r_done);
        n   = bump(n);
      end
    end
    // the byte itself
    if (c1) begin
      res = put(res, n, '{data: b1, valid: 1'b1, done: 1'b0});
      n   = bump(n);
      f   = content_len(len, mode_r, lim);
      len = f[15:0];
      if (f[16]) begin
        res = put(res, n, r_done);
        n   = bump(n);
      end
    end
    // separator closes the open piece
    if (cm) begin
      if (len != '0) begin
        res = put(res, n, r_done);
        n   = bump(n);
      end
      len = '0;
    end
    // end of text: release held newline, then close
    if (c2) begin
      res = put(res, n, '{data: tcs_pkg::NL_BYTE, valid: 1'b1, done: 1'b0});
      n   = bump(n);
      f   = content_len(len, mode_r, lim);
      len = f[15:0];
      if (f[16]) begin
        res = put(res, n, r_done);
        n   = bump(n);
      end
    end
    if (in_text_end) begin
      if (mode_r == tcs_pkg::MODE_WHOLE || len != '0) begin
        res = put(res, n, r_done);
        n   = bump(n);
      end
      len = '0;
    end

    held_nxt    = in_text_end ? 1'b0 : held_mid;
    len_nxt     = len;
    q_entry.res = res;
    q_entry.cnt = n;
  end

  assign q_push = accept && (q_entry.cnt != '0);

  // State and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= tcs_pkg::MODE_PARA;
      max_piece_r <= tcs_pkg::DEFAULT_PIECE;
      held_r      <= 1'b0;
      len_r       <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == tcs_pkg::REG_SPLIT_MODE) mode_r <= tcs_pkg::mode_t'(cfg_wdata[1:0]);
        if (cfg_index == tcs_pkg::REG_MAX_PIECE)  max_piece_r <= cfg_wdata[15:0];
      end
      if (accept) begin
        held_r <= held_nxt;
        len_r  <= len_nxt;
      end
    end
  end

endmodule

// ===== sv/tcs_queue.sv =====
// Short queue of result lists between front and back end.
module tcs_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  tcs_pkg::entry_t  wr_entry,
  output logic             full,
  input  logic             pop,
  output tcs_pkg::q_head_t head
);

  tcs_pkg::entry_t           mem_r [tcs_pkg::Q_DEPTH];
  logic [tcs_pkg::Q_AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [tcs_pkg::Q_CW-1:0]  cnt_r;

  function automatic logic [tcs_pkg::Q_AW-1:0] ptr_inc(logic [tcs_pkg::Q_AW-1:0] p);
    return (p == tcs_pkg::Q_AW'(tcs_pkg::Q_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full       = (cnt_r == tcs_pkg::Q_CW'(tcs_pkg::Q_DEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.head  = mem_r[rd_ptr_r];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_entry;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== sv/tcs_back.sv =====
// Back end: plays out the queued result lists one result per cycle unless the output is stalled.
module tcs_back (
  input  logic             clk,
  input  logic             rst_n,
  input  tcs_pkg::q_head_t head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_byte,
  output logic             out_byte_valid,
  output logic             out_chunk_done,
  output logic             out_run_last
);

  logic [tcs_pkg::RES_IW-1:0] idx_r;
  logic                       out_valid_r;
  logic [7:0]                 data_r;
  logic                       bval_r, done_r, last_r;
  logic                       load, is_last;
  tcs_pkg::res_t              cur;

  assign cur     = head.head.res[idx_r];
  assign is_last = ({1'b0, idx_r} == head.head.cnt - 1'b1);
  assign load    = head.valid && (!out_valid_r || !out_stall);
  assign pop     = load && is_last;

  // Output register and position within the list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        idx_r       <= is_last ? '0 : idx_r + 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= cur.data;
      bval_r <= cur.valid;
      done_r <= cur.done;
      last_r <= is_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = data_r;
  assign out_byte_valid = bval_r;
  assign out_chunk_done = done_r;
  assign out_run_last   = last_r;

`ifndef SYNTH
  // Popping a list leaves its last result in the output register
  a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_run_last)
    else $error("queue popped without last result loaded");

  // A list still being played out stays at the queue head
  a_head_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_run_last |-> head.valid)
    else $error("list left queue before its last result");

  // A result carries either a byte or a piece end
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_byte_valid != out_chunk_done))
    else $error("result is neither byte nor piece end");

  // Loading a non-final result advances the position by one
  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    load && !is_last |=> idx_r == $past(idx_r) + 1'b1)
    else $error("list position did not advance");
`endif

endmodule

// ===== test/text_chunk_splitter_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the text chunk splitter: directed and random texts.
module text_chunk_splitter_tb;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned DRAIN_WAIT  = 8;
  localparam int unsigned IDLE_PCT    = 18;

  // One expected result as seen on the output channel
  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       done;
    logic       last;
  } chunk_res_t;

  logic                       clk;
  logic                       rst_n           = 1'b0;
  logic                       cfg_we          = 1'b0;
  logic                       cfg_index       = tcs_pkg::REG_SPLIT_MODE;
  logic [tcs_pkg::CFG_DW-1:0] cfg_wdata       = '0;
  logic                       in_valid        = 1'b0;
  logic                       in_stall;
  logic [7:0]                 in_text_byte    = 8'h00;
  logic                       in_byte_present = 1'b0;
  logic                       in_text_end     = 1'b0;
  logic                       out_valid;
  logic                       out_stall       = 1'b0;
  logic [7:0]                 out_byte;
  logic                       out_byte_valid;
  logic                       out_chunk_done;
  logic                       out_run_last;

  // Predictor state: configuration and chunking state
  tcs_pkg::mode_t mdl_mode      = tcs_pkg::MODE_PARA;
  logic [15:0]    mdl_piece_max = tcs_pkg::DEFAULT_PIECE;
  logic           mdl_held_nl   = 1'b0;
  logic [15:0]    mdl_piece_len = 16'd0;

  chunk_res_t  step_res[$];
  chunk_res_t  chunk_expect[$];

  int unsigned err_count   = 0;
  int unsigned items_sent  = 0;
  int unsigned res_checked = 0;
  int unsigned cfg_writes  = 0;
  int unsigned cycles      = 0;
  bit          calm        = 1'b0;

  text_chunk_splitter dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_text_byte    (in_text_byte),
    .in_byte_present (in_byte_present),
    .in_text_end     (in_text_end),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_byte_valid  (out_byte_valid),
    .out_chunk_done  (out_chunk_done),
    .out_run_last    (out_run_last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
  end

  task automatic flag_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    err_count++;
  endtask

  // ---------------------------------------------------------------
  // Chunking predictor
  // ---------------------------------------------------------------
  function automatic void add_marker();
    step_res.push_back('{data: 8'h00, valid: 1'b0, done: 1'b1, last: 1'b0});
  endfunction

  function automatic void add_content(input logic [7:0] b);
    logic [15:0] limit;
    limit = (mdl_piece_max != 16'd0) ? mdl_piece_max : tcs_pkg::DEFAULT_PIECE;
    step_res.push_back('{data: b, valid: 1'b1, done: 1'b0, last: 1'b0});
    if (mdl_mode == tcs_pkg::MODE_WHOLE) begin
      // whole text: count only, saturating
      if (mdl_piece_len != tcs_pkg::LEN_MAX) mdl_piece_len = mdl_piece_len + 16'd1;
    end else begin
      mdl_piece_len = mdl_piece_len + 16'd1;
      if (mdl_piece_len >= limit) begin
        add_marker();
        mdl_piece_len = 16'd0;
      end
    end
  endfunction

  function automatic void close_open_piece();
    if (mdl_piece_len != 16'd0) add_marker();
    mdl_piece_len = 16'd0;
  endfunction

  function automatic void predict_chunks(input logic [7:0] b, input logic pres,
                                         input logic fin);
    step_res.delete();
    if (pres) begin
      if (mdl_mode == tcs_pkg::MODE_PARA) begin
        if (mdl_held_nl) begin
          // second newline completes the separator, else release it
          mdl_held_nl = 1'b0;
          if (b == tcs_pkg::NL_BYTE) begin
            close_open_piece();
          end else begin
            add_content(tcs_pkg::NL_BYTE);
            add_content(b);
          end
        end else if (b == tcs_pkg::NL_BYTE) begin
          mdl_held_nl = 1'b1;
        end else begin
          add_content(b);
        end
      end else begin
        // newline left over from paragraph mode goes out as content
        if (mdl_held_nl) begin
          mdl_held_nl = 1'b0;
          add_content(tcs_pkg::NL_BYTE);
        end
        if ((mdl_mode == tcs_pkg::MODE_LINE && b == tcs_pkg::NL_BYTE) ||
            (mdl_mode == tcs_pkg::MODE_PAGE && b == tcs_pkg::FF_BYTE)) begin
          close_open_piece();
        end else begin
          add_content(b);
        end
      end
    end
    if (fin) begin
      if (mdl_held_nl) begin
        mdl_held_nl = 1'b0;
        add_content(tcs_pkg::NL_BYTE);
      end
      if (mdl_mode == tcs_pkg::MODE_WHOLE) add_marker();
      else close_open_piece();
      mdl_piece_len = 16'd0;
    end
    if (step_res.size() != 0) step_res[step_res.size()-1].last = 1'b1;
    foreach (step_res[i]) chunk_expect.push_back(step_res[i]);
  endfunction

  // ---------------------------------------------------------------
  // Result checker: a transaction completes at the edge after this sample
  // ---------------------------------------------------------------
  always @(negedge clk) begin : result_check
    chunk_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (chunk_expect.size() == 0) begin
        flag_mismatch($sformatf("unexpected result byte=%02h bv=%0b done=%0b last=%0b",
                                out_byte, out_byte_valid, out_chunk_done, out_run_last));
      end else begin
        want = chunk_expect.pop_front();
        res_checked++;
        if (out_byte !== want.data)
          flag_mismatch($sformatf("out_byte %02h, expected %02h", out_byte, want.data));
        if (out_byte_valid !== want.valid)
          flag_mismatch($sformatf("out_byte_valid %0b, expected %0b",
                                  out_byte_valid, want.valid));
        if (out_chunk_done !== want.done)
          flag_mismatch($sformatf("out_chunk_done %0b, expected %0b",
                                  out_chunk_done, want.done));
        if (out_run_last !== want.last)
          flag_mismatch($sformatf("out_run_last %0b, expected %0b",
                                  out_run_last, want.last));
      end
    end
  end

  // ---------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------
  // Send one transaction; valid stays high on return
  task automatic send_item(input logic [7:0] b, input logic pres, input logic fin);
    bit taken;
    while (!calm && ($urandom_range(0, 99) < IDLE_PCT)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_text_byte    <= b;
    in_byte_present <= pres;
    in_text_end     <= fin;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      if (taken) predict_chunks(b, pres, fin);
      @(posedge clk);
    end
    if (pres || fin) items_sent++;
  endtask

  // Let everything expected arrive, plus the pipeline latency
  task automatic drain_block();
    in_valid <= 1'b0;
    while (chunk_expect.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [tcs_pkg::CFG_DW-1:0] val);
    drain_block();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == tcs_pkg::REG_SPLIT_MODE) mdl_mode = tcs_pkg::mode_t'(val[1:0]);
    else mdl_piece_max = val;
    cfg_writes++;
  endtask

  // Mode write with random upper bits, which the block must ignore
  task automatic set_mode(input tcs_pkg::mode_t m);
    logic [tcs_pkg::CFG_DW-1:0] v;
    v = tcs_pkg::CFG_DW'($urandom_range(0, 16'hFFFF));
    v[1:0] = m;
    write_reg(tcs_pkg::REG_SPLIT_MODE, v);
  endtask

  // Random text byte, biased towards separators
  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25) return tcs_pkg::NL_BYTE;
    if (r < 35) return tcs_pkg::FF_BYTE;
    return 8'($urandom_range(0, 255));
  endfunction

  // ---------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------
  // Reset settings: paragraph mode, 4096-byte pieces
  task automatic test_default_paragraph();
    send_item(8'h61, 1'b1, 1'b0);
    send_item(tcs_pkg::NL_BYTE, 1'b1, 1'b0);
    send_item(tcs_pkg::NL_BYTE, 1'b1, 1'b0);   // double newline closes the piece
    send_item(8'h00, 1'b1, 1'b0);              // NUL is content
    send_item(tcs_pkg::NL_BYTE, 1'b1, 1'b0);   // held back
    send_item(8'hFF, 1'b1, 1'b0);              // releases the newline
    send_item(8'h5A, 1'b0, 1'b0);              // no byte, no end: nothing
    send_item(tcs_pkg::NL_BYTE, 1'b1, 1'b1);   // held newline released at end
    send_item(8'h00, 1'b0, 1'b1);              // bare end, empty piece
  endtask

  task automatic test_line_and_page();
    set_mode(tcs_pkg::MODE_LINE);
    send_item(8'h78, 1'b1, 1'b0);
    send_item(tcs_pkg::NL_BYTE, 1'b1, 1'b0);
    send_item(tcs_pkg::NL_BYTE, 1'b1, 1'b0);   // empty chunk skipped
    send_item(tcs_pkg::FF_BYTE, 1'b1, 1'b1);
    set_mode(tcs_pkg::MODE_PAGE);
    send_item(tcs_pkg::NL_BYTE, 1'b1, 1'b0);   // newline is content here
    send_item(tcs_pkg::FF_BYTE, 1'b1, 1'b0);
    send_item(8'hA5, 1'b0, 1'b1);
  endtask

  task automatic test_whole_text();
    set_mode(tcs_pkg::MODE_WHOLE);
    send_item(8'hC3, 1'b0, 1'b1);              // empty text still gives one chunk
    send_item(tcs_pkg::NL_BYTE, 1'b1, 1'b0);
    send_item(tcs_pkg::FF_BYTE, 1'b1, 1'b1);
  endtask

  task automatic test_piece_limits();
    set_mode(tcs_pkg::MODE_LINE);
    write_reg(tcs_pkg::REG_MAX_PIECE, 16'd1);
    send_item(8'h71, 1'b1, 1'b1);
    write_reg(tcs_pkg::REG_MAX_PIECE, 16'd8);
    send_item(8'h31, 1'b1, 1'b0);
    send_item(8'h32, 1'b1, 1'b0);
    send_item(8'h33, 1'b1, 1'b0);
    // limit lowered below the open piece length
    write_reg(tcs_pkg::REG_MAX_PIECE, 16'd2);
    send_item(8'h34, 1'b1, 1'b1);
  endtask

  // Held newline meets a mode change
  task automatic test_mode_switch_held_newline();
    set_mode(tcs_pkg::MODE_PARA);
    write_reg(tcs_pkg::REG_MAX_PIECE, 16'd0);
    send_item(tcs_pkg::NL_BYTE, 1'b1, 1'b0);
    set_mode(tcs_pkg::MODE_LINE);
    send_item(8'h6B, 1'b1, 1'b1);
  endtask

  task automatic test_random_texts();
    logic [15:0] piece;
    int unsigned budget;
    int unsigned text_len;
    int unsigned r;
    for (int ph = 0; ph < 12; ph++) begin
      // settings for this phase, extremes first
      if (ph == 0) begin
        set_mode(tcs_pkg::MODE_PARA);
        piece = 16'd0;
      end else if (ph == 1) begin
        set_mode(tcs_pkg::MODE_WHOLE);
        piece = 16'hFFFF;
      end else begin
        set_mode(tcs_pkg::mode_t'($urandom_range(0, 3)));
        case ($urandom_range(0, 7))
          0:       piece = 16'd0;
          1:       piece = 16'hFFFF;
          6:       piece = 16'($urandom_range(7, 40));
          7:       piece = 16'($urandom_range(0, 16'hFFFF));
          default: piece = 16'($urandom_range(1, 6));
        endcase
      end
      write_reg(tcs_pkg::REG_MAX_PIECE, piece);
      calm = (ph == 5);
      budget = items_sent + (calm ? 34 : 18);
      while (items_sent < budget) begin
        text_len = $urandom_range(0, 12);
        for (int k = 0; k < text_len; k++) begin
          if ($urandom_range(0, 99) < 5) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
          else send_item(pick_byte(), 1'b1, 1'b0);
        end
        // text end: bare mark, byte with end, or none so the text runs on
        r = $urandom_range(0, 99);
        if (r < 45) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        else if (r < 90) send_item(pick_byte(), 1'b1, 1'b1);
      end
      calm = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_paragraph();
    test_line_and_page();
    test_whole_text();
    test_piece_limits();
    test_mode_switch_held_newline();
    test_random_texts();
    drain_block();
    $display("Covered %0d text transactions in all four split modes, %0d register writes,",
             items_sent, cfg_writes);
    $display("piece sizes from 1 to 65535 and the default; %0d results compared.",
             res_checked);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== text_chunk_splitter.f =====
sv/tcs_pkg.sv
sv/tcs_front.sv
sv/tcs_queue.sv
sv/tcs_back.sv
sv/text_chunk_splitter.sv
test/text_chunk_splitter_tb.sv
